// File: sv/lsic_pkg.sv
// Shared types and constants for the labelled sorted-set intersection counter.
`default_nettype none
package lsic_pkg;

  localparam int MAX_LIST = 1024;
  localparam int ADDR_W   = $clog2(MAX_LIST);
  localparam int LEN_W    = $clog2(MAX_LIST + 1);
  localparam int COUNT_W  = 11;
  localparam int VID_W    = 32;
  localparam int LABEL_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [VID_W-1:0]   vertex_id;
    logic [LABEL_W-1:0] vertex_label;
    logic [LABEL_W-1:0] query_label;
  } lsic_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               overflow;
  } lsic_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_DONE
  } lsic_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic finish;
  } lsic_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic merge_last;
    logic out_free;
  } lsic_sts_t;

endpackage
`default_nettype wire

// File: sv/lsic_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lsic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/lsic_ctrl.sv
// Controller state machine: input handshake and merge sequencing.
`default_nettype none
module lsic_ctrl
  import lsic_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic [1:0] in_cmd,
  output logic           in_ready,
  input  wire lsic_sts_t sts,
  output lsic_ctl_t      ctl
);

  lsic_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_cmd)
            CMD_LOAD_A: ctl.load_a = 1'b1;
            CMD_LOAD_B: ctl.load_b = 1'b1;
            CMD_START: begin
              ctl.start  = 1'b1;
              state_next = sts.empty ? S_DONE : S_MERGE;
            end
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        ctl.step = 1'b1;
        if (sts.merge_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/lsic_dpath.sv
// Datapath: list memories, lengths, merge pointers, match counter, output register.
`default_nettype none
module lsic_dpath
  import lsic_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire lsic_in_t  in_data,
  input  wire lsic_ctl_t ctl,
  output lsic_sts_t      sts,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lsic_out_t      out_data
);

  logic [LEN_W-1:0]   len_a, len_b;
  logic [LEN_W-1:0]   ia, ib, ia_next, ib_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [LABEL_W-1:0] qlab;
  logic               dropped;
  logic               full_a, full_b;
  logic [VID_W-1:0]   a_vid, b_vid;
  logic [LABEL_W-1:0] a_lab;
  logic               a_le, b_le, hit;
  logic [ADDR_W-1:0]  raddr_a, raddr_b;

  assign full_a = (len_a == LEN_W'(MAX_LIST));
  assign full_b = (len_b == LEN_W'(MAX_LIST));

  lsic_ram #(
    .WIDTH (LABEL_W + VID_W),
    .DEPTH (MAX_LIST)
  ) u_ram_a (
    .clk   (clk),
    .we    (ctl.load_a && !full_a),
    .waddr (len_a[ADDR_W-1:0]),
    .wdata ({in_data.vertex_label, in_data.vertex_id}),
    .raddr (raddr_a),
    .rdata ({a_lab, a_vid})
  );

  lsic_ram #(
    .WIDTH (VID_W),
    .DEPTH (MAX_LIST)
  ) u_ram_b (
    .clk   (clk),
    .we    (ctl.load_b && !full_b),
    .waddr (len_b[ADDR_W-1:0]),
    .wdata (in_data.vertex_id),
    .raddr (raddr_b),
    .rdata (b_vid)
  );

  // One merge step per cycle: compare, advance, and fetch the next pair.
  always_comb begin
    a_le       = (a_vid <= b_vid);
    b_le       = (b_vid <= a_vid);
    hit        = (a_vid == b_vid) && (a_lab == qlab);
    ia_next    = ia + LEN_W'(a_le);
    ib_next    = ib + LEN_W'(b_le);
    count_next = (hit && count != COUNT_MAX) ? count + COUNT_W'(1) : count;
    raddr_a    = ctl.step ? ia_next[ADDR_W-1:0] : '0;
    raddr_b    = ctl.step ? ib_next[ADDR_W-1:0] : '0;
  end

  assign sts.empty      = (len_a == '0) || (len_b == '0);
  assign sts.merge_last = (ia_next == len_a) || (ib_next == len_b);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_a     <= '0;
      len_b     <= '0;
      dropped   <= 1'b0;
      ia        <= '0;
      ib        <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load_a) begin
        if (full_a) begin
          dropped <= 1'b1;
        end else begin
          len_a <= len_a + LEN_W'(1);
        end
      end
      if (ctl.load_b) begin
        if (full_b) begin
          dropped <= 1'b1;
        end else begin
          len_b <= len_b + LEN_W'(1);
        end
      end
      if (ctl.start) begin
        ia    <= '0;
        ib    <= '0;
        count <= '0;
      end
      if (ctl.step) begin
        ia    <= ia_next;
        ib    <= ib_next;
        count <= count_next;
      end
      if (ctl.finish) begin
        len_a     <= '0;
        len_b     <= '0;
        dropped   <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      qlab <= in_data.query_label;
    end
    if (ctl.finish) begin
      out_data.match_count <= count;
      out_data.overflow    <= dropped;
    end
  end

endmodule
`default_nettype wire

// File: sv/labelled_sorted_set_intersection_count.sv
// Top level of the labelled sorted-set intersection counter.
//
// Input channel (in_valid/in_ready/in_data) carries one command per transaction:
// load A appends a vertex and its label to list A, load B appends a vertex to
// list B, start runs the two-pointer merge. A load into a full list is dropped
// and sets the overflow flag reported with the next result.
// in_ready is high only while idle, and drops from an accepted start until its
// result is handed to the output register.
// A start transaction produces one result transaction on the output channel
// (out_valid/out_ready/out_data): the count of common vertices whose list A
// label equals query_label, plus the overflow flag. The merge advances one
// step per cycle, limited by the registered read port of each list memory;
// it takes at most len_a + len_b - 1 steps, and none when a list is empty.
// After the result, both lists and the flag are cleared.
// The result sits in an output register: while the receiver stalls, loads are
// still accepted; a following start merges, then holds until the slot frees.
// Reset (rst, synchronous) empties both lists and drops any pending result;
// list memory contents are not cleared and need not be.
`default_nettype none
module labelled_sorted_set_intersection_count
  import lsic_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lsic_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lsic_out_t     out_data
);

  lsic_ctl_t ctl;
  lsic_sts_t sts;

  // Sequence loads, merge steps and result hand-off.
  lsic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Hold the lists, walk them, count matches.
  lsic_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A start transaction leaves the block busy in the cycle after it is accepted.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cmd == CMD_START |=> !in_ready)
    else $error("input accepted right after a start");

  // No transaction is taken while the merge runs.
  a_merge_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> !in_ready)
    else $error("input ready during merge");

  // A new result only follows a finish command.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.finish))
    else $error("result appeared without a finish");

  // At most one datapath command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load_a, ctl.load_b, ctl.start, ctl.step, ctl.finish}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// File: dv/tb_labelled_sorted_set_intersection_count.sv
// Self-checking testbench for the labelled sorted-set intersection counter.
module tb_labelled_sorted_set_intersection_count;
  timeunit 1ns;
  timeprecision 1ps;

  import lsic_pkg::*;

  // Command code that the block must ignore; the package leaves it unnamed.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int HOLD_CYCLES  = 600;            // long receiver hold-off
  localparam int DRAIN_CYCLES = 2 * MAX_LIST + 8; // longest merge plus margin
  localparam int RANDOM_ITEMS = 740;
  localparam int TIMEOUT_NS   = 4_000_000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lsic_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lsic_out_t out_data;

  labelled_sorted_set_intersection_count dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Commands waiting for the driver, and results the block still owes us.
  lsic_in_t  pending[$];
  lsic_out_t expected_results[$];

  // Flow control knobs, changed by the main sequence between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  bit in_fire        = 1'b0;

  // Bookkeeping for the final verdict and summary.
  int failures         = 0;
  int results_checked  = 0;
  int transactions_in  = 0;
  int overflow_results = 0;
  int peak_count       = 0;
  int stim_items       = 0;

  // Shadow copy of the two neighbour lists and the drop flag.
  logic [VID_W-1:0]   a_vertex [MAX_LIST];
  logic [LABEL_W-1:0] a_label  [MAX_LIST];
  logic [VID_W-1:0]   b_vertex [MAX_LIST];
  int len_a   = 0;
  int len_b   = 0;
  bit dropped = 1'b0;

  // Two-pointer merge over the shadow lists: a hit needs equal vertices and
  // the list A label equal to the query label. Advance the smaller side, or
  // both on a tie. Saturate at the widest count the field can carry.
  function automatic logic [COUNT_W-1:0] count_labelled_common(
    logic [LABEL_W-1:0] want);
    int ia = 0;
    int ib = 0;
    int hits = 0;
    logic [VID_W-1:0] va;
    logic [VID_W-1:0] vb;
    while (ia < len_a && ib < len_b) begin
      va = a_vertex[ia];
      vb = b_vertex[ib];
      if (va == vb && a_label[ia] == want && hits < COUNT_MAX) hits++;
      if (va <= vb) ia++;
      if (vb <= va) ib++;
    end
    return hits[COUNT_W-1:0];
  endfunction

  // Apply one accepted transaction to the shadow state; a start queues the
  // result it must produce and then empties both lists and the flag.
  function automatic void absorb_command(lsic_in_t t);
    lsic_out_t r;
    case (t.cmd)
      CMD_LOAD_A: begin
        if (len_a < MAX_LIST) begin
          a_vertex[len_a] = t.vertex_id;
          a_label[len_a]  = t.vertex_label;
          len_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      CMD_LOAD_B: begin
        if (len_b < MAX_LIST) begin
          b_vertex[len_b] = t.vertex_id;
          len_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      CMD_START: begin
        r.match_count = count_labelled_common(t.query_label);
        r.overflow    = dropped;
        expected_results.push_back(r);
        len_a   = 0;
        len_b   = 0;
        dropped = 1'b0;
      end
      default: begin
        // unused command: no state change, no result
      end
    endcase
  endfunction

  // Monitor: sample both channels at the rising edge. Absorb the input
  // transaction first; a result can never belong to a start taken this edge.
  always @(posedge clk) begin
    lsic_out_t want;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      absorb_command(in_data);
      transactions_in++;
    end
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (out_data.overflow) overflow_results++;
      if (out_data.match_count > peak_count) peak_count = out_data.match_count;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result: count %0d overflow %0b",
                 $time, out_data.match_count, out_data.overflow);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.match_count !== want.match_count) begin
          $display("%0t ns: match_count mismatch: expected %0d, actual %0d",
                   $time, want.match_count, out_data.match_count);
          failures++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t ns: overflow mismatch: expected %0b, actual %0b",
                   $time, want.overflow, out_data.overflow);
          failures++;
        end
      end
    end
  end

  // Driver: at the falling edge, hold the current transaction until it is
  // taken, then present the next one or go idle at the phase's idle rate.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at the phase's rate; on request, hold off for a long
  // count of cycles so the output slot stays full and the input backs up.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic lsic_in_t make_cmd(logic [1:0] cmd, logic [VID_W-1:0] vid,
                                        logic [LABEL_W-1:0] vlab,
                                        logic [LABEL_W-1:0] qlab);
    lsic_in_t t;
    t.cmd          = cmd;
    t.vertex_id    = vid;
    t.vertex_label = vlab;
    t.query_label  = qlab;
    return t;
  endfunction

  // Queue one command; ignored commands do not count toward the item total.
  function automatic void queue_item(lsic_in_t t);
    pending.push_back(t);
    if (t.cmd != CMD_UNUSED) stim_items++;
  endfunction

  function automatic void queue_cmd(logic [1:0] cmd, logic [VID_W-1:0] vid,
                                    logic [LABEL_W-1:0] vlab,
                                    logic [LABEL_W-1:0] qlab);
    queue_item(make_cmd(cmd, vid, vlab, qlab));
  endfunction

  // One list pair plus its start. Mostly ascending lists drawn from a shared
  // run of values, so vertices land in A, B or both; now and then scramble
  // the values into a tiny range so the lists come out unsorted. A and B
  // loads interleave at random, with stray unused commands mixed in.
  task automatic queue_random_set(int max_vals);
    lsic_in_t a_loads[$];
    lsic_in_t b_loads[$];
    logic [VID_W-1:0]   v;
    logic [LABEL_W-1:0] q;
    logic [LABEL_W-1:0] lab;
    int n;
    int pick;
    bit scrambled;
    q         = 8'($urandom);
    scrambled = ($urandom_range(0, 9) == 0);
    v         = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
    n         = $urandom_range(0, max_vals);
    for (int k = 0; k < n; k++) begin
      if (scrambled) v = $urandom_range(0, 15);
      else v += $urandom_range(1, 4);
      pick = $urandom_range(0, 2);
      lab  = ($urandom_range(0, 2) != 0) ? q : 8'($urandom);
      if (pick != 1) a_loads.push_back(make_cmd(CMD_LOAD_A, v, lab, 8'($urandom)));
      if (pick != 0) b_loads.push_back(make_cmd(CMD_LOAD_B, v, 8'($urandom),
                                                8'($urandom)));
    end
    while (a_loads.size() + b_loads.size() != 0) begin
      if ($urandom_range(0, 19) == 0)
        queue_cmd(CMD_UNUSED, $urandom, 8'($urandom), 8'($urandom));
      if (b_loads.size() == 0 || (a_loads.size() != 0 && $urandom_range(0, 1)))
        queue_item(a_loads.pop_front());
      else
        queue_item(b_loads.pop_front());
    end
    queue_cmd(CMD_START, $urandom, 8'($urandom), q);
  endtask

  // Block until every queued transaction is taken and every result is back.
  task automatic wait_drained();
    while (pending.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random_phase(int items, int idle_pct, int stall_pct);
    int goal;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = stim_items + items;
    while (stim_items < goal)
      queue_random_set(($urandom_range(0, 15) == 0) ? 48 : 8);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty lists, extreme vertices and labels, unused command,
    // unsorted lists, duplicate vertices.
    queue_cmd(CMD_START, '1, '1, 8'h00);
    queue_cmd(CMD_LOAD_B, 32'd5, 8'h00, 8'h00);
    queue_cmd(CMD_START, 32'd0, 8'h00, 8'h00);
    queue_cmd(CMD_LOAD_A, 32'd0, 8'hFF, 8'h00);
    queue_cmd(CMD_UNUSED, '1, '1, '1);
    queue_cmd(CMD_LOAD_A, 32'd7, 8'h03, 8'h00);
    queue_cmd(CMD_LOAD_A, '1, 8'hFF, 8'h00);
    queue_cmd(CMD_LOAD_B, 32'd0, 8'h00, 8'hFF);
    queue_cmd(CMD_LOAD_B, 32'd7, 8'h00, 8'hFF);
    queue_cmd(CMD_LOAD_B, '1, 8'h00, 8'hFF);
    queue_cmd(CMD_START, 32'd0, 8'h00, 8'hFF);
    queue_cmd(CMD_LOAD_A, 32'd9, 8'h01, 8'h00);
    queue_cmd(CMD_LOAD_A, 32'd2, 8'h01, 8'h00);
    queue_cmd(CMD_LOAD_A, 32'd5, 8'h01, 8'h00);
    queue_cmd(CMD_LOAD_B, 32'd2, 8'h00, 8'h00);
    queue_cmd(CMD_LOAD_B, 32'd5, 8'h00, 8'h00);
    queue_cmd(CMD_LOAD_B, 32'd9, 8'h00, 8'h00);
    queue_cmd(CMD_START, 32'd0, 8'h00, 8'h01);
    queue_cmd(CMD_LOAD_A, 32'd4, 8'h00, 8'h00);
    queue_cmd(CMD_LOAD_A, 32'd4, 8'h00, 8'h00);
    queue_cmd(CMD_LOAD_B, 32'd4, 8'h00, 8'h00);
    queue_cmd(CMD_START, 32'd0, 8'h00, 8'h00);
    wait_drained();

    // Fill list A to capacity with ascending vertices and push one extra
    // load so it is dropped; list B picks a few of them, the first and the
    // last included. Count with the overflow flag set; a second start must
    // see the flag and lists cleared.
    for (int i = 0; i < MAX_LIST; i++) begin
      queue_cmd(CMD_LOAD_A, VID_W'(i), 8'hA5, 8'($urandom));
    end
    queue_cmd(CMD_LOAD_A, '1, 8'hA5, 8'h00);
    for (int i = 0; i < MAX_LIST; i += 128) begin
      queue_cmd(CMD_LOAD_B, VID_W'(i), 8'($urandom), 8'($urandom));
      queue_cmd(CMD_LOAD_B, VID_W'(i + 127), 8'($urandom), 8'($urandom));
    end
    queue_cmd(CMD_START, 32'd0, 8'h00, 8'hA5);
    queue_cmd(CMD_START, 32'd0, 8'h00, 8'h00);
    wait_drained();

    // Back-pressure: hold the receiver off while small sets keep arriving,
    // so the result slot fills and the next start stalls the input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (12) queue_random_set(4);
    wait_drained();

    // Random sets under each flow-control mix.
    run_random_phase(RANDOM_ITEMS / 4, 0, 0);
    run_random_phase(RANDOM_ITEMS / 4, 80, 0);
    run_random_phase(RANDOM_ITEMS / 4, 0, 80);
    run_random_phase(RANDOM_ITEMS / 4, 6, 6);

    // Give any stray result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input transactions and %0d results, %0d of them flagging drops.",
             transactions_in, results_checked, overflow_results);
    $display("Largest count seen %0d; included a %0d-cycle receiver hold-off.",
             peak_count, HOLD_CYCLES);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t ns: timeout with %0d results outstanding",
             $time, expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
